>>> rtl/core/rsqe_pkg.sv
// Shared types, constants and CORDIC/corner helper functions of the rotated sprite quad expander.
// Used by every module of the block; depends on nothing.
package rsqe_pkg;

  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int ODEPTH    = 8;
  localparam int OAW       = $clog2(ODEPTH);
  localparam int CORDIC_N  = 16;
  localparam int LAST_VTX  = 5;

  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [25:0] TRIG_ONE  = 26'sd16777216;

  typedef struct packed {
    logic signed [31:0] display_x;
    logic signed [31:0] display_y;
    logic signed [31:0] width;
    logic signed [31:0] height;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        tex_u0;
    logic [15:0]        tex_v0;
    logic [15:0]        tex_u1;
    logic [15:0]        tex_v1;
    logic               last_sprite;
  } sprite_t;

  typedef struct packed {
    logic signed [25:0] cs;
    logic signed [25:0] sn;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [2:0]         vertex_index;
    logic               last_of_sprite;
    logic               last_of_list;
    logic               saturated;
  } vert_t;

  // Arctangent of 2^-i, one turn = 2^24.
  function automatic logic signed [24:0] atan_val(input int i);
    logic signed [24:0] r;
    case (i)
      0:       r = 25'sd2097152;
      1:       r = 25'sd1238021;
      2:       r = 25'sd654136;
      3:       r = 25'sd332050;
      4:       r = 25'sd166669;
      5:       r = 25'sd83416;
      6:       r = 25'sd41718;
      7:       r = 25'sd20860;
      8:       r = 25'sd10430;
      9:       r = 25'sd5215;
      10:      r = 25'sd2608;
      11:      r = 25'sd1304;
      12:      r = 25'sd652;
      13:      r = 25'sd326;
      14:      r = 25'sd163;
      default: r = 25'sd81;
    endcase
    return r;
  endfunction

  // Corner order BL, BR, TR, TR, TL, BL.
  function automatic logic corner_qx(input logic [2:0] k);
    return (k == 3'd1) || (k == 3'd2) || (k == 3'd3);
  endfunction

  function automatic logic corner_qy(input logic [2:0] k);
    return (k == 3'd2) || (k == 3'd3) || (k == 3'd4);
  endfunction

endpackage

>>> rtl/core/rsqe_cordic.sv
// Pipelined sine/cosine unit: one CORDIC iteration per stage plus a quadrant fold.
// Depends on rsqe_pkg.
module rsqe_cordic
  import rsqe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [15:0] angle,
  output logic        out_valid,
  output trig_t       out_trig
);

  logic               vld_r  [0:CORDIC_N];
  logic signed [32:0] x_r    [0:CORDIC_N];
  logic signed [32:0] y_r    [0:CORDIC_N];
  logic signed [24:0] z_r    [0:CORDIC_N];
  logic [1:0]         quad_r [0:CORDIC_N];
  logic               zero_r [0:CORDIC_N];
  logic               ov_r;
  trig_t              trig_r;

  logic signed [26:0] xr, yr;
  logic signed [25:0] c, s;
  trig_t              trig_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_N; i++) vld_r[i] <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 0; i < CORDIC_N; i++) vld_r[i+1] <= vld_r[i];
      ov_r <= vld_r[CORDIC_N];
    end
    x_r[0]    <= CORDIC_X0;
    y_r[0]    <= '0;
    z_r[0]    <= $signed({3'b000, angle[13:0], 8'h00});
    quad_r[0] <= angle[15:14];
    zero_r[0] <= (angle[13:0] == 14'd0);
    for (int i = 0; i < CORDIC_N; i++) begin
      if (!z_r[i][24]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_val(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_val(i);
      end
      quad_r[i+1] <= quad_r[i];
      zero_r[i+1] <= zero_r[i];
    end
    trig_r <= trig_nxt;
  end

  always_comb begin
    xr = 27'((x_r[CORDIC_N] + 33'sd32) >>> 6);
    yr = 27'((y_r[CORDIC_N] + 33'sd32) >>> 6);
    if (xr > 27'(TRIG_ONE))       c = TRIG_ONE;
    else if (xr < -27'(TRIG_ONE)) c = -TRIG_ONE;
    else                          c = 26'(xr);
    if (yr > 27'(TRIG_ONE))       s = TRIG_ONE;
    else if (yr < -27'(TRIG_ONE)) s = -TRIG_ONE;
    else                          s = 26'(yr);
    if (zero_r[CORDIC_N]) begin
      c = TRIG_ONE;
      s = '0;
    end
    case (quad_r[CORDIC_N])
      2'd0:    begin trig_nxt.cs = c;  trig_nxt.sn = s;  end
      2'd1:    begin trig_nxt.cs = -s; trig_nxt.sn = c;  end
      2'd2:    begin trig_nxt.cs = -c; trig_nxt.sn = -s; end
      default: begin trig_nxt.cs = s;  trig_nxt.sn = -c; end
    endcase
  end

  assign out_valid = ov_r;
  assign out_trig  = trig_r;

endmodule

>>> rtl/core/rsqe_front.sv
// Front end: takes sprite words, starts their sine/cosine and parks them in a short queue.
// Depends on rsqe_pkg and rsqe_cordic.
module rsqe_front
  import rsqe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    full,
  input  sprite_t sprite,
  input  logic [15:0] angle,
  output logic    q_valid,
  input  logic    q_pop,
  output sprite_t q_sprite,
  output trig_t   q_trig
);

  sprite_t          pay_mem  [0:QDEPTH-1];
  trig_t            trig_mem [0:QDEPTH-1];
  logic [QAW:0]     used_r, ready_r;
  logic [QAW-1:0]   wp_r, tw_r, rp_r;
  logic             acc, t_valid;
  trig_t            t_trig;

  // A slot is reserved at intake, so the trig pipeline never needs to stall.
  assign full = (used_r == (QAW+1)'(QDEPTH));
  assign acc  = push && !full;

  rsqe_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc),
    .angle     (angle),
    .out_valid (t_valid),
    .out_trig  (t_trig)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      ready_r <= '0;
      wp_r    <= '0;
      tw_r    <= '0;
      rp_r    <= '0;
    end else begin
      used_r  <= used_r + (QAW+1)'(acc) - (QAW+1)'(q_pop);
      ready_r <= ready_r + (QAW+1)'(t_valid) - (QAW+1)'(q_pop);
      if (acc)     wp_r <= wp_r + 1'b1;
      if (t_valid) tw_r <= tw_r + 1'b1;
      if (q_pop)   rp_r <= rp_r + 1'b1;
    end
    if (acc)     pay_mem[wp_r]  <= sprite;
    if (t_valid) trig_mem[tw_r] <= t_trig;
  end

  assign q_valid  = (ready_r != '0);
  assign q_sprite = pay_mem[rp_r];
  assign q_trig   = trig_mem[rp_r];

endmodule

>>> rtl/core/rsqe_back.sv
// Back end: expands one queued sprite into six vertices through a multiply pipeline
// and an output queue. Depends on rsqe_pkg.
module rsqe_back
  import rsqe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_pop,
  input  sprite_t q_sprite,
  input  trig_t   q_trig,
  output logic    empty,
  input  logic    pop,
  output vert_t   head
);

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [15:0]        u;
    logic [15:0]        v;
    logic [2:0]         k;
    logic               last;
    trig_t              t;
  } carry_t;

  sprite_t        cur_r;
  trig_t          trig_r;
  logic           busy_r;
  logic [2:0]     k_r;
  logic [OAW:0]   oused_r, ocnt_r;
  logic [OAW-1:0] owp_r, orp_r;
  vert_t          omem [0:ODEPTH-1];

  logic               issue, opop;
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  carry_t             c1_nxt, c1_r, c2_r, c3_r, c4_r, c5_r;
  logic signed [16:0] ddx, ddy;
  logic signed [48:0] mx_nxt, my_nxt, mx_r, my_r;
  logic signed [34:0] sx_r, sy_r;
  logic signed [17:0] sxh, sxl, syh, syl;
  logic signed [43:0] cxh_r, cxl_r, sxh_r, sxl_r, cyh_r, cyl_r, syh_r, syl_r;
  logic signed [61:0] cx_r, snx_r, cy_r, sny_r;
  logic signed [37:0] rx_r, ry_r;
  logic signed [38:0] px, py;
  vert_t              wv;

  assign issue = busy_r && (oused_r != (OAW+1)'(ODEPTH));
  assign q_pop = q_valid && (!busy_r || (issue && k_r == 3'(LAST_VTX)));
  assign opop  = pop && !empty;

  always_comb begin
    ddx = (corner_qx(k_r) ? 17'sd16384 : 17'sd0) - 17'(cur_r.origin_x);
    ddy = (corner_qy(k_r) ? 17'sd16384 : 17'sd0) - 17'(cur_r.origin_y);
    mx_nxt = 49'(ddx) * 49'(cur_r.width);
    my_nxt = 49'(ddy) * 49'(cur_r.height);
    c1_nxt.dx   = cur_r.display_x;
    c1_nxt.dy   = cur_r.display_y;
    c1_nxt.u    = corner_qx(k_r) ? cur_r.tex_u1 : cur_r.tex_u0;
    c1_nxt.v    = corner_qy(k_r) ? cur_r.tex_v1 : cur_r.tex_v0;
    c1_nxt.k    = k_r;
    c1_nxt.last = cur_r.last_sprite;
    c1_nxt.t    = trig_r;
    sxh = sx_r[34:17];
    sxl = $signed({1'b0, sx_r[16:0]});
    syh = sy_r[34:17];
    syl = $signed({1'b0, sy_r[16:0]});
  end

  always_comb begin
    px = 39'(c5_r.dx) + 39'(rx_r);
    py = 39'(c5_r.dy) + 39'(ry_r);
    wv.saturated = 1'b0;
    if (px > 39'sh007FFFFFFF) begin
      wv.pos_x = 32'sh7FFFFFFF; wv.saturated = 1'b1;
    end else if (px < -39'sh080000000) begin
      wv.pos_x = 32'sh80000000; wv.saturated = 1'b1;
    end else begin
      wv.pos_x = 32'(px);
    end
    if (py > 39'sh007FFFFFFF) begin
      wv.pos_y = 32'sh7FFFFFFF; wv.saturated = 1'b1;
    end else if (py < -39'sh080000000) begin
      wv.pos_y = 32'sh80000000; wv.saturated = 1'b1;
    end else begin
      wv.pos_y = 32'(py);
    end
    wv.tex_u          = c5_r.u;
    wv.tex_v          = c5_r.v;
    wv.vertex_index   = c5_r.k;
    wv.last_of_sprite = (c5_r.k == 3'(LAST_VTX));
    wv.last_of_list   = wv.last_of_sprite && c5_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      k_r     <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      oused_r <= '0;
      ocnt_r  <= '0;
      owp_r   <= '0;
      orp_r   <= '0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (issue) begin
        if (k_r == 3'(LAST_VTX)) begin
          busy_r <= 1'b0;
          k_r    <= '0;
        end else begin
          k_r <= k_r + 3'd1;
        end
      end
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      oused_r <= oused_r + (OAW+1)'(issue) - (OAW+1)'(opop);
      ocnt_r  <= ocnt_r + (OAW+1)'(v5_r) - (OAW+1)'(opop);
      if (v5_r) owp_r <= owp_r + 1'b1;
      if (opop) orp_r <= orp_r + 1'b1;
    end
    if (q_pop) begin
      cur_r  <= q_sprite;
      trig_r <= q_trig;
    end
    c1_r  <= c1_nxt;
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
    c2_r  <= c1_r;
    sx_r  <= 35'((mx_r + 49'sd8192) >>> 14);
    sy_r  <= 35'((my_r + 49'sd8192) >>> 14);
    c3_r  <= c2_r;
    cxh_r <= 44'(c2_r.t.cs) * 44'(sxh);
    cxl_r <= 44'(c2_r.t.cs) * 44'(sxl);
    sxh_r <= 44'(c2_r.t.sn) * 44'(sxh);
    sxl_r <= 44'(c2_r.t.sn) * 44'(sxl);
    cyh_r <= 44'(c2_r.t.cs) * 44'(syh);
    cyl_r <= 44'(c2_r.t.cs) * 44'(syl);
    syh_r <= 44'(c2_r.t.sn) * 44'(syh);
    syl_r <= 44'(c2_r.t.sn) * 44'(syl);
    c4_r  <= c3_r;
    cx_r  <= (62'(cxh_r) <<< 17) + 62'(cxl_r);
    snx_r <= (62'(sxh_r) <<< 17) + 62'(sxl_r);
    cy_r  <= (62'(cyh_r) <<< 17) + 62'(cyl_r);
    sny_r <= (62'(syh_r) <<< 17) + 62'(syl_r);
    c5_r  <= c4_r;
    rx_r  <= 38'((cx_r - sny_r + 62'sd8388608) >>> 24);
    ry_r  <= 38'((snx_r + cy_r + 62'sd8388608) >>> 24);
    if (v5_r) omem[owp_r] <= wv;
  end

  assign empty = (ocnt_r == '0);
  assign head  = omem[orp_r];

endmodule

>>> rtl/core/rotated_sprite_quad_expander_top.sv
// Top level of the rotated sprite quad expander: front end, back end and port wiring.
// Depends on rsqe_pkg, rsqe_front and rsqe_back.
//
// Usage: each word pushed on the in_ side is one sprite (anchor, scale, pivot, angle,
// texture rectangle and a last-in-list mark). For every sprite the out_ side yields six
// vertex words, BL, BR, TR, TR, TL, BL, forming two triangles. Push a word when in_full
// is low; take the head vertex with out_pop while out_empty is low.
// A sprite reaches the sprite queue through 16 CORDIC stages, one input stage and one
// quadrant fold stage; once the back end picks it up, its first vertex reaches the
// out_ ports through two multiply stages, two rounding stages, a sum stage and the
// saturating add into the output queue.
// Throughput: one vertex per cycle while the output queue has room, set by the single
// vertex stream of the back end. Intake is limited to four sprites in flight between
// push and the start of their expansion.
// Reset clears all queues and pipeline valid flags; in_full and out_empty go low and
// high respectively. When the receiver stops popping, the output queue (8 words) fills,
// the back end stops issuing vertices, the sprite queue fills and in_full rises;
// nothing is dropped and nothing resumes out of order.
module rotated_sprite_quad_expander_top
  import rsqe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_display_x,
  input  logic signed [31:0] in_display_y,
  input  logic signed [31:0] in_width,
  input  logic signed [31:0] in_height,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [15:0]        in_angle,
  input  logic [15:0]        in_tex_u0,
  input  logic [15:0]        in_tex_v0,
  input  logic [15:0]        in_tex_u1,
  input  logic [15:0]        in_tex_v1,
  input  logic               in_last_sprite,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]        out_tex_u,
  output logic [15:0]        out_tex_v,
  output logic [2:0]         out_vertex_index,
  output logic               out_last_of_sprite,
  output logic               out_last_of_list,
  output logic               out_saturated
);

  sprite_t sp, q_sprite;
  trig_t   q_trig;
  logic    q_valid, q_pop;
  vert_t   head;

  // Pack the sprite word; the angle travels separately into the trig pipeline.
  always_comb begin
    sp.display_x   = in_display_x;
    sp.display_y   = in_display_y;
    sp.width       = in_width;
    sp.height      = in_height;
    sp.origin_x    = in_origin_x;
    sp.origin_y    = in_origin_y;
    sp.tex_u0      = in_tex_u0;
    sp.tex_v0      = in_tex_v0;
    sp.tex_u1      = in_tex_u1;
    sp.tex_v1      = in_tex_v1;
    sp.last_sprite = in_last_sprite;
  end

  rsqe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .full     (in_full),
    .sprite   (sp),
    .angle    (in_angle),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_sprite (q_sprite),
    .q_trig   (q_trig)
  );

  rsqe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_sprite (q_sprite),
    .q_trig   (q_trig),
    .empty    (out_empty),
    .pop      (out_pop),
    .head     (head)
  );

  // The head of the output queue is shown directly on the result ports.
  assign out_pos_x          = head.pos_x;
  assign out_pos_y          = head.pos_y;
  assign out_tex_u          = head.tex_u;
  assign out_tex_v          = head.tex_v;
  assign out_vertex_index   = head.vertex_index;
  assign out_last_of_sprite = head.last_of_sprite;
  assign out_last_of_list   = head.last_of_list;
  assign out_saturated      = head.saturated;

endmodule

>>> rtl/core/rsqe_checker.sv
// Port-level checker for the rotated sprite quad expander, bound to the top level.
// Depends on rsqe_pkg and rotated_sprite_quad_expander_top.
module rsqe_checker
  import rsqe_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_vertex_index,
  input logic       out_last_of_sprite,
  input logic       out_last_of_list
);

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_vertex_index <= 3'(LAST_VTX))
    else $error("vertex index out of range");

  a_last_sprite: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_last_of_sprite == (out_vertex_index == 3'(LAST_VTX)))
    else $error("last_of_sprite does not match vertex index");

  a_last_list: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_last_of_list |-> out_last_of_sprite)
    else $error("last_of_list off the sixth vertex");

  a_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop && !out_empty && out_vertex_index != 3'(LAST_VTX) |=>
      out_empty || out_vertex_index == $past(out_vertex_index) + 3'd1)
    else $error("vertex order broken");

endmodule

bind rotated_sprite_quad_expander_top rsqe_checker u_rsqe_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_vertex_index   (out_vertex_index),
  .out_last_of_sprite (out_last_of_sprite),
  .out_last_of_list   (out_last_of_list)
);
